@@ rtl/htfd_pkg.sv @@
// Shared constants, types and the CRC-8 byte step for the frame decoder.
// Used by htfd_crc8 and humidity_temp_frame_decoder_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package htfd_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t        CRC_POLY    = 8'h31;
  localparam byte_t        CRC_INIT    = 8'h00;
  localparam logic [15:0]  STATUS_MASK = 16'hFFFC;
  localparam logic [14:0]  T_SCALE     = 15'd17572;
  localparam logic [14:0]  T_OFFSET    = 15'd4685;
  localparam logic [10:0]  RH_SCALE    = 11'd1250;
  // Humidity offset of sixty tenths less the rounding term of five tenths.
  localparam logic [10:0]  RH_BIAS     = 11'd55;
  // Below this raw value the rounded humidity is zero or negative.
  localparam logic [10:0]  RH_ZERO_LIM = 11'd65;
  localparam logic [6:0]   RH_MAX      = 7'd100;
  localparam logic [3:0]   ROUND_HALF  = 4'd5;
  // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for every 16-bit x.
  localparam logic [15:0]  DIV10_MUL   = 16'd52429;
  localparam int           DIV10_SHIFT = 19;

  // One byte of CRC-8, MSB first.
  function automatic byte_t crc8_byte(input byte_t c_in, input byte_t data);
    byte_t c;
    c = c_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/htfd_crc8.sv @@
// CRC-8 check of one two-byte word against its received CRC byte.
// Depends on htfd_pkg for the polynomial, seed and byte step.
`timescale 1ns / 1ps
`default_nettype none

module htfd_crc8
  import htfd_pkg::*;
(
  input  wire byte_t msb,
  input  wire byte_t lsb,
  input  wire byte_t crc,
  output logic       match
);

  byte_t crc_hi;
  byte_t crc_full;

  always_comb begin
    crc_hi   = crc8_byte(CRC_INIT, msb);
    crc_full = crc8_byte(crc_hi, lsb);
    match    = (crc_full == crc);
  end

endmodule

`default_nettype wire

@@ rtl/humidity_temp_frame_decoder_core.sv @@
// Top level of the humidity/temperature frame decoder: a three-stage pipeline.
// Depends on htfd_pkg and htfd_crc8.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// A frame word (two data words of the sensor, each with its CRC-8 byte) is
// offered on the six byte ports and taken at any rising edge where start is
// high and busy is low. The block never refuses a word, so busy is always
// low and a new frame may be taken in every cycle.
// Stage one registers the frame. Stage two checks both CRC-8 values
// (polynomial 0x31, seed zero), strips the status bits and forms the two
// scaled products. Stage three removes the offsets, rounds temperature to
// tenths (halves away from zero), rounds humidity to whole percent, clamps
// it to 0..100 and zeroes both values when a CRC fails.
// The result word appears on frame_ok, temp_tenths and humidity_pct with done
// high once the frame has passed the stage one, two and three registers in
// turn. Throughput is one frame per cycle, set by the pipeline having one
// register per stage and no shared unit.
// Each result is shown for exactly one cycle; the receiver cannot stall it
// and must take it at the edge that ends that cycle.
// A synchronous reset clears the stage valid flags and done, which drops
// any frames in flight; payload registers are not reset.
module humidity_temp_frame_decoder_core
  import htfd_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  byte_t temp_msb,
  input  wire  byte_t temp_lsb,
  input  wire  byte_t temp_crc,
  input  wire  byte_t hum_msb,
  input  wire  byte_t hum_lsb,
  input  wire  byte_t hum_crc,
  output logic        done,
  output logic        frame_ok,
  output logic signed [11:0] temp_tenths,
  output logic [6:0]  humidity_pct
);

  // The pipeline has no back pressure, so the block is never busy.
  assign busy = 1'b0;

  // Stage one: registered frame.
  logic  p1_valid;
  byte_t p1_temp_msb, p1_temp_lsb, p1_temp_crc;
  byte_t p1_hum_msb, p1_hum_lsb, p1_hum_crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      p1_temp_msb <= temp_msb;
      p1_temp_lsb <= temp_lsb;
      p1_temp_crc <= temp_crc;
      p1_hum_msb  <= hum_msb;
      p1_hum_lsb  <= hum_lsb;
      p1_hum_crc  <= hum_crc;
    end
  end

  // Stage two: CRC checks and the scaling products.
  logic        temp_match, hum_match;
  logic [15:0] t_word, h_word;
  logic [30:0] t_prod;
  logic [26:0] h_prod;

  htfd_crc8 u_temp_crc (
    .msb   (p1_temp_msb),
    .lsb   (p1_temp_lsb),
    .crc   (p1_temp_crc),
    .match (temp_match)
  );

  htfd_crc8 u_hum_crc (
    .msb   (p1_hum_msb),
    .lsb   (p1_hum_lsb),
    .crc   (p1_hum_crc),
    .match (hum_match)
  );

  always_comb begin
    t_word = {p1_temp_msb, p1_temp_lsb} & STATUS_MASK;
    h_word = {p1_hum_msb, p1_hum_lsb} & STATUS_MASK;
    // Only bit sixteen and up of each product is kept downstream.
    t_prod = 31'(t_word) * 31'(T_SCALE);
    h_prod = 27'(h_word) * 27'(RH_SCALE);
  end

  logic        p2_valid;
  logic        p2_ok;
  logic [14:0] p2_t_raw;
  logic [10:0] p2_h_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p2_ok    <= temp_match && hum_match;
    p2_t_raw <= t_prod[30:16];
    p2_h_raw <= h_prod[26:16];
  end

  // Stage three: offsets, rounding by a reciprocal multiply, clamp.
  logic        t_neg;
  logic [14:0] t_mag_wide;
  logic [13:0] t_mag;
  logic [29:0] t_div_prod;
  logic [10:0] t_quot;
  logic [11:0] t_signed_next;
  logic [10:0] h_adj;
  logic [26:0] h_div_prod;
  logic [7:0]  h_quot;
  logic [6:0]  h_pct_next;

  always_comb begin
    // Hundredths are t_raw - offset; round magnitude then restore sign.
    t_neg = p2_t_raw < T_OFFSET;
    if (t_neg) begin
      t_mag_wide = T_OFFSET - p2_t_raw + 15'(ROUND_HALF);
    end else begin
      t_mag_wide = p2_t_raw - T_OFFSET + 15'(ROUND_HALF);
    end
    t_mag      = t_mag_wide[13:0];
    t_div_prod = 30'(t_mag) * 30'(DIV10_MUL);
    t_quot     = t_div_prod[29:DIV10_SHIFT];
    if (t_neg) begin
      t_signed_next = -{1'b0, t_quot};
    end else begin
      t_signed_next = {1'b0, t_quot};
    end

    // Humidity tenths plus five, truncated; values that round to zero or
    // below come out as zero.
    h_adj      = p2_h_raw - RH_BIAS;
    h_div_prod = 27'(h_adj) * 27'(DIV10_MUL);
    h_quot     = h_div_prod[26:DIV10_SHIFT];
    if (p2_h_raw < RH_ZERO_LIM) begin
      h_pct_next = 7'd0;
    end else if (h_quot > 8'(RH_MAX)) begin
      h_pct_next = RH_MAX;
    end else begin
      h_pct_next = h_quot[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p2_valid;
    end
  end

  // A frame that fails either CRC reports zeros in both value fields.
  always_ff @(posedge clk) begin
    frame_ok     <= p2_ok;
    temp_tenths  <= p2_ok ? t_signed_next : 12'sd0;
    humidity_pct <= p2_ok ? h_pct_next : 7'd0;
  end

endmodule

`default_nettype wire

@@ verif/htfd_score_pkg.sv @@
// Scoreboard for the frame decoder bench: expected readings and their comparison.
// Self-contained; imported by humidity_temp_frame_decoder_core_tb.
`timescale 1ns / 1ps

package htfd_score_pkg;

  localparam logic [7:0]  SENSOR_POLY = 8'h31;
  localparam logic [15:0] DATA_BITS   = 16'hFFFC;
  localparam int          TEMP_GAIN   = 17572;
  localparam int          TEMP_OFS    = 4685;
  localparam int          RH_GAIN     = 1250;
  localparam int          RH_OFS      = 60;
  localparam int          RH_CEIL     = 100;

  typedef struct packed {
    logic              ok;
    logic signed [11:0] tenths;
    logic [6:0]        pct;
  } reading_t;

  // CRC-8 of one 16-bit word, bit serial, MSB first, zero seed.
  function automatic logic [7:0] word_crc(input logic [15:0] w);
    logic [7:0] c;
    logic       fb;
    c = 8'h00;
    for (int i = 15; i >= 0; i--) begin
      fb = c[7] ^ w[i];
      c = c << 1;
      if (fb) begin
        c = c ^ SENSOR_POLY;
      end
    end
    return c;
  endfunction

  // Temperature in hundredths of a degree, status bits dropped.
  function automatic int temp_centi(input logic [15:0] w);
    longint p;
    p = (longint'(TEMP_GAIN) * longint'(w & DATA_BITS)) >>> 16;
    return int'(p) - TEMP_OFS;
  endfunction

  class reading_scoreboard;
    reading_t    pending_q[$];
    int unsigned n_good;
    int unsigned n_bad;
    int unsigned n_seen;
    int unsigned n_wrong;

    function void note_frame(input logic [7:0] tm, input logic [7:0] tl,
                             input logic [7:0] tc, input logic [7:0] hm,
                             input logic [7:0] hl, input logic [7:0] hc);
      reading_t    r;
      logic [15:0] tw;
      logic [15:0] hw;
      int          cent;
      int          t10;
      int          rh10;
      int          pct;
      tw = {tm, tl};
      hw = {hm, hl};
      r  = '0;
      if (word_crc(tw) != tc || word_crc(hw) != hc) begin
        n_bad++;
      end else begin
        cent = temp_centi(tw);
        // C-style division truncates, so the sign-matched bias rounds halves outward.
        t10  = (cent + (cent >= 0 ? 5 : -5)) / 10;
        rh10 = int'((longint'(RH_GAIN) * longint'(hw & DATA_BITS)) >>> 16) - RH_OFS;
        pct  = (rh10 + 5) / 10;
        if (pct < 0) begin
          pct = 0;
        end
        if (pct > RH_CEIL) begin
          pct = RH_CEIL;
        end
        r.ok     = 1'b1;
        r.tenths = t10[11:0];
        r.pct    = pct[6:0];
        n_good++;
      end
      pending_q.push_back(r);
    endfunction

    function void check_reading(input logic ok, input logic signed [11:0] tenths,
                                input logic [6:0] pct);
      reading_t exp;
      n_seen++;
      if (pending_q.size() == 0) begin
        $error("Result word with no frame outstanding");
        n_wrong++;
        return;
      end
      exp = pending_q.pop_front();
      if (ok !== exp.ok) begin
        $error("frame_ok: expected %0d, got %0d", exp.ok, ok);
        n_wrong++;
      end
      if (tenths !== exp.tenths) begin
        $error("temp_tenths: expected %0d, got %0d", $signed(exp.tenths), $signed(tenths));
        n_wrong++;
      end
      if (pct !== exp.pct) begin
        $error("humidity_pct: expected %0d, got %0d", exp.pct, pct);
        n_wrong++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_q.size();
    endfunction
  endclass

endpackage

@@ verif/humidity_temp_frame_decoder_core_tb.sv @@
// Self-checking bench for the humidity/temperature frame decoder core.
// Depends on htfd_pkg (port types), htfd_score_pkg and the core RTL.
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_core_tb;
  import htfd_pkg::byte_t;
  import htfd_score_pkg::*;

  // Cycles to let pass after the last reading; the pipeline is three stages deep.
  localparam int TAIL_CYCLES = 8;

  logic               clk;
  logic               rst;
  logic               start;
  byte_t              temp_msb;
  byte_t              temp_lsb;
  byte_t              temp_crc;
  byte_t              hum_msb;
  byte_t              hum_lsb;
  byte_t              hum_crc;
  wire                busy;
  wire                done;
  wire                frame_ok;
  wire signed [11:0]  temp_tenths;
  wire [6:0]          humidity_pct;

  reading_scoreboard  board;
  int unsigned        idle_pct;
  int unsigned        burst_left;

  humidity_temp_frame_decoder_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .temp_msb     (temp_msb),
    .temp_lsb     (temp_lsb),
    .temp_crc     (temp_crc),
    .hum_msb      (hum_msb),
    .hum_lsb      (hum_lsb),
    .hum_crc      (hum_crc),
    .done         (done),
    .frame_ok     (frame_ok),
    .temp_tenths  (temp_tenths),
    .humidity_pct (humidity_pct)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the core hangs or drops a reading.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Every result word is up for exactly one cycle and cannot be held off, so it is
  // checked at the rising edge that closes that cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      board.check_reading(frame_ok, temp_tenths, humidity_pct);
    end
  end

  // Offers one frame word. Inputs only change on the falling edge; the word is
  // taken at the first rising edge with busy low. Before the word the sender may
  // sit idle for a random number of cycles, except inside a back-to-back burst.
  task automatic send_frame(input logic [15:0] tw, input byte_t tc,
                            input logic [15:0] hw, input byte_t hc);
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(99) < 4) begin
      burst_left = $urandom_range(30, 8);
    end else begin
      while ($urandom_range(99) < idle_pct) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
    @(negedge clk);
    start    = 1'b1;
    temp_msb = tw[15:8];
    temp_lsb = tw[7:0];
    temp_crc = tc;
    hum_msb  = hw[15:8];
    hum_lsb  = hw[7:0];
    hum_crc  = hc;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    board.note_frame(tw[15:8], tw[7:0], tc, hw[15:8], hw[7:0], hc);
  endtask

  // A frame whose two checksums are both correct.
  task automatic send_good(input logic [15:0] tw, input logic [15:0] hw);
    send_frame(tw, word_crc(tw), hw, word_crc(hw));
  endtask

  // The sender goes quiet until every outstanding reading has come back, then
  // waits out a tail of TAIL_CYCLES to show anything unexpected.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (board.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Mostly uniform words; one in eight sits at the very bottom or top of the
  // range with random status bits.
  function automatic logic [15:0] random_word();
    logic [15:0] w;
    w = 16'($urandom);
    if ($urandom_range(7) == 0) begin
      w = $urandom_range(1) ? (16'hFFFF ^ 16'($urandom_range(3))) : 16'($urandom_range(3));
    end
    return w;
  endfunction

  // Most frames are well formed so that the conversion path is exercised; the
  // rest carry a random checksum or one with a single flipped bit.
  task automatic random_frame();
    logic [15:0] tw;
    logic [15:0] hw;
    byte_t       tc;
    byte_t       hc;
    int unsigned kind;
    tw   = random_word();
    hw   = random_word();
    tc   = word_crc(tw);
    hc   = word_crc(hw);
    kind = $urandom_range(99);
    if (kind < 6) begin
      tc = 8'($urandom);
      hc = 8'($urandom);
    end else if (kind < 11) begin
      tc = tc ^ 8'(1 << $urandom_range(7));
    end else if (kind < 16) begin
      hc = hc ^ 8'(1 << $urandom_range(7));
    end
    send_frame(tw, tc, hw, hc);
  endtask

  task automatic run_phase(input int unsigned pct, input int unsigned count);
    idle_pct   = pct;
    burst_left = 0;
    repeat (count) random_frame();
  endtask

  initial begin
    logic [15:0] half_up;
    logic [15:0] half_down;
    bit          got_up;
    bit          got_down;
    int          cent;

    // Known levels on every input from time zero.
    rst        = 1'b1;
    start      = 1'b0;
    temp_msb   = '0;
    temp_lsb   = '0;
    temp_crc   = '0;
    hum_msb    = '0;
    hum_lsb    = '0;
    hum_crc    = '0;
    idle_pct   = 0;
    burst_left = 0;
    board      = new();

    // Find raw temperature words that land exactly on a half tenth, one above
    // and one below zero, so rounding away from zero is hit in both directions.
    half_up   = '0;
    half_down = '0;
    got_up    = 1'b0;
    got_down  = 1'b0;
    for (int w = 0; w < 65536; w += 4) begin
      cent = temp_centi(16'(w));
      if (!got_up && cent > 0 && cent % 10 == 5) begin
        half_up = 16'(w);
        got_up  = 1'b1;
      end
      if (!got_down && cent < 0 && cent % 10 == -5) begin
        half_down = 16'(w);
        got_down  = 1'b1;
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed frames: word extremes, status bits alone, alternating patterns,
    // the temperature zero crossing and both half-way roundings, humidity
    // below zero, at the 0/1 and 99/100 steps and above full scale, and
    // checksum failures on either word or both.
    send_good(16'h0000, 16'h0000);
    send_good(16'hFFFF, 16'hFFFF);
    send_good(16'hFFFC, 16'hFFFC);
    send_good(16'h0003, 16'h0003);
    send_good(16'h8000, 16'h8000);
    send_good(16'hAAAA, 16'h5555);
    send_good(16'h5555, 16'hAAAA);
    send_good(16'h4440, 16'h0D4C);
    send_good(16'h4444, 16'h0D50);
    send_good(half_up, 16'hD810);
    send_good(half_down, 16'hD814);
    send_good(16'h6000, 16'hE000);
    send_good(16'h1000, 16'hF000);
    send_frame(16'h6000, ~word_crc(16'h6000), 16'h6000, word_crc(16'h6000));
    send_frame(16'h6000, word_crc(16'h6000), 16'h6000, word_crc(16'h6000) ^ 8'h01);
    send_frame(16'h6000, word_crc(16'h6000) ^ 8'h80, 16'h6000, ~word_crc(16'h6000));
    send_frame(16'hFFFF, 8'h00, 16'h0000, 8'hFF);
    send_frame(16'h0000, 8'hFF, 16'hFFFF, word_crc(16'hFFFF));
    drain();

    // Random frames under three sender idle mixes: none, heavy and moderate.
    run_phase(0, 310);
    drain();
    run_phase(82, 310);
    drain();
    run_phase(31, 310);
    drain();

    $display("Checked %0d readings: %0d frames with good checksums, %0d rejected.",
             board.n_seen, board.n_good, board.n_bad);
    $display("Sender idle mixes of 0, 82 and 31 percent, with back-to-back bursts.");
    if (board.n_wrong == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
